@@ design/fb_pkg.sv @@
// Package for the 802.15.4 frame builder: frame layout constants, register
// indexes, shared structs, the header byte selector and the byte-wide CRC step.
// No dependencies.
package fb_pkg;

  // Frame layout.
  localparam int PREAMBLE_BYTES = 4;
  localparam int HDR_LEN        = 11;
  localparam int FCS_LEN        = 2;
  localparam int POS_SFD        = PREAMBLE_BYTES;
  localparam int POS_LEN        = PREAMBLE_BYTES + 1;
  localparam int POS_HDR        = PREAMBLE_BYTES + 2;
  localparam int POS_PAY        = POS_HDR + HDR_LEN;
  localparam int POS_LAST       = POS_PAY + FCS_LEN;
  localparam int POS_W          = $clog2(POS_LAST + 1);
  localparam int HDR_IDX_W      = $clog2(HDR_LEN);

  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [HDR_IDX_W-1:0] hdr_idx_t;

  // Fixed codes and CRC settings.
  localparam logic [7:0]  SFD_BYTE = 8'hA7;
  localparam logic [15:0] CRC_POLY = 16'h1201;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [6:0]  MIN_LEN  = 7'd2;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_CONTROL   = 3'd0,
    REG_SEQUENCE_NUMBER = 3'd1,
    REG_DEST_PAN_ID     = 3'd2,
    REG_DEST_ADDRESS    = 3'd3,
    REG_SRC_PAN_ID      = 3'd4,
    REG_SRC_ADDRESS     = 3'd5,
    REG_PAYLOAD_LENGTH  = 3'd6
  } cfg_idx_t;

  // Header contents as seen by the emitter.
  typedef struct packed {
    logic [15:0] frame_control;
    logic [7:0]  sequence_number;
    logic [15:0] dest_pan_id;
    logic [15:0] dest_address;
    logic [15:0] src_pan_id;
    logic [15:0] src_address;
    logic [7:0]  len_byte;
  } hdr_t;

  // One accepted payload word with its place in the frame.
  typedef struct packed {
    logic       start;
    logic       last;
    logic [7:0] data;
  } job_t;

  // Status returned by the emitter.
  typedef struct packed {
    logic done;
    logic crc_idle;
  } emit_status_t;

  // Header byte at a given index, fields little-endian.
  function automatic logic [7:0] hdr_byte(hdr_t h, hdr_idx_t idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = h.frame_control[7:0];
      4'd1:    b = h.frame_control[15:8];
      4'd2:    b = h.sequence_number;
      4'd3:    b = h.dest_pan_id[7:0];
      4'd4:    b = h.dest_pan_id[15:8];
      4'd5:    b = h.dest_address[7:0];
      4'd6:    b = h.dest_address[15:8];
      4'd7:    b = h.src_pan_id[7:0];
      4'd8:    b = h.src_pan_id[15:8];
      4'd9:    b = h.src_address[7:0];
      4'd10:   b = h.src_address[15:8];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Reflected CRC over one byte, LSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in;
    for (int k = 0; k < 8; k++) begin
      if (c[0] ^ b[k]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ design/fb_if.sv @@
// Stream interfaces of the frame builder: payload words in, frame words out.
// Depends on nothing.
interface fb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;

  modport source (output valid, output payload_byte, input ready);
  modport sink   (input valid, input payload_byte, output ready);
endinterface

interface fb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

@@ design/fb_emitter.sv @@
// Frame word sequencer: walks the positions of one accepted word, keeps the
// running CRC and holds the output register. Depends on fb_pkg and fb_out_if.
module fb_emitter
  import fb_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         job_valid,
  input  job_t         job,
  input  hdr_t         hdr,
  input  logic         load,
  input  logic         load_start,
  output emit_status_t status,
  fb_out_if.source     out_if
);

  pos_t        pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_end_r;

  logic        move;
  logic        done;
  pos_t        final_pos;
  logic [7:0]  sel_byte;
  logic        crc_take;
  pos_t        hdr_off;

  // A word moves into the output register when that register is free or empties this cycle.
  assign move      = job_valid && (!out_valid_r || out_if.ready);
  assign final_pos = job.last ? POS_W'(POS_LAST) : POS_W'(POS_PAY);
  assign done      = move && (pos_r == final_pos);
  assign hdr_off   = pos_r - POS_W'(POS_HDR);
  assign crc_take  = (pos_r >= POS_W'(POS_HDR)) && (pos_r <= POS_W'(POS_PAY));

  // Select the frame word at the current position.
  always_comb begin
    if (pos_r < POS_W'(POS_SFD)) begin
      sel_byte = 8'h00;
    end else if (pos_r == POS_W'(POS_SFD)) begin
      sel_byte = SFD_BYTE;
    end else if (pos_r == POS_W'(POS_LEN)) begin
      sel_byte = hdr.len_byte;
    end else if (pos_r < POS_W'(POS_PAY)) begin
      sel_byte = hdr_byte(hdr, hdr_off[HDR_IDX_W-1:0]);
    end else if (pos_r == POS_W'(POS_PAY)) begin
      sel_byte = job.data;
    end else if (pos_r == POS_W'(POS_PAY + 1)) begin
      sel_byte = ~crc_r[7:0];
    end else begin
      sel_byte = ~crc_r[15:8];
    end
  end

  // Position and CRC next values.
  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    if (load) begin
      pos_nxt = load_start ? '0 : POS_W'(POS_PAY);
    end else if (move) begin
      pos_nxt = pos_r + POS_W'(1);
    end
    if (move && crc_take) begin
      crc_nxt = crc_byte(crc_r, sel_byte);
    end else if (done && job.last) begin
      crc_nxt = CRC_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output word and frame-end register.
  always_ff @(posedge clk) begin
    if (move) begin
      out_byte_r <= sel_byte;
      out_end_r  <= (pos_r == POS_W'(POS_LAST));
    end
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.out_byte  = out_byte_r;
  assign out_if.frame_end = out_end_r;

  assign status.done     = done;
  assign status.crc_idle = (crc_r == CRC_INIT);

endmodule

@@ design/ieee802154_frame_builder.sv @@
// 802.15.4 frame builder top level: configuration registers, frame tracking
// and the word register feeding the sequencer. Depends on fb_pkg, fb_if, fb_emitter.
// An accepted word passes the word register, then the output register.
// Throughput: one output word per cycle while words are supplied and the receiver
// is ready; a mid-frame payload word yields only its own word, the first word of a
// frame also the preamble, SFD, length and header, and the last also the FCS.
// Reset: synchronous active-low; registers return to their defaults, idle.
module ieee802154_frame_builder
  import fb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fb_in_if.sink                 in_if,
  fb_out_if.source              out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [15:0]  frame_control_r;
  logic [7:0]   sequence_number_r;
  logic [15:0]  dest_pan_id_r;
  logic [15:0]  dest_address_r;
  logic [15:0]  src_pan_id_r;
  logic [15:0]  src_address_r;
  logic [6:0]   payload_length_r;

  logic         in_frame_r;
  logic [6:0]   cnt_r;
  logic [6:0]   cnt_nxt;
  logic         job_valid_r;
  job_t         job_r;

  logic         accept;
  logic         start;
  logic         last;
  logic [6:0]   len_eff;
  hdr_t         hdr;
  emit_status_t st;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_control_r   <= 16'h8841;
      sequence_number_r <= 8'h01;
      dest_pan_id_r     <= 16'h2222;
      dest_address_r    <= 16'h1234;
      src_pan_id_r      <= 16'h4444;
      src_address_r     <= 16'hABCD;
      payload_length_r  <= 7'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_CONTROL:   frame_control_r   <= cfg_wdata;
        REG_SEQUENCE_NUMBER: sequence_number_r <= cfg_wdata[7:0];
        REG_DEST_PAN_ID:     dest_pan_id_r     <= cfg_wdata;
        REG_DEST_ADDRESS:    dest_address_r    <= cfg_wdata;
        REG_SRC_PAN_ID:      src_pan_id_r      <= cfg_wdata;
        REG_SRC_ADDRESS:     src_address_r     <= cfg_wdata;
        REG_PAYLOAD_LENGTH:  payload_length_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Short lengths behave as two so header and FCS never share a word.
  assign len_eff = (payload_length_r < MIN_LEN) ? MIN_LEN : payload_length_r;

  assign hdr.frame_control   = frame_control_r;
  assign hdr.sequence_number = sequence_number_r;
  assign hdr.dest_pan_id     = dest_pan_id_r;
  assign hdr.dest_address    = dest_address_r;
  assign hdr.src_pan_id      = src_pan_id_r;
  assign hdr.src_address     = src_address_r;
  assign hdr.len_byte        = {1'b0, len_eff} + 8'(HDR_LEN + FCS_LEN);

  // A new word is taken when the word register is free or empties this cycle.
  assign in_if.ready = !job_valid_r || st.done;
  assign accept      = in_if.valid && in_if.ready;
  assign start       = !in_frame_r;
  assign cnt_nxt     = (start ? 7'd0 : cnt_r) + 7'd1;
  assign last        = (cnt_nxt >= len_eff);

  // Frame tracking and the word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r  <= 1'b0;
      cnt_r       <= '0;
      job_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        job_valid_r <= 1'b1;
        in_frame_r  <= !last;
        cnt_r       <= last ? 7'd0 : cnt_nxt;
      end else if (st.done) begin
        job_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.start <= start;
      job_r.last  <= last;
      job_r.data  <= in_if.payload_byte;
    end
  end

  fb_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (job_valid_r),
    .job        (job_r),
    .hdr        (hdr),
    .load       (accept),
    .load_start (start),
    .status     (st),
    .out_if     (out_if)
  );

  // Between frames the CRC must be back at its initial value.
  a_crc_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_frame_r && !job_valid_r) |-> st.crc_idle)
    else $error("CRC not restored between frames");

  // The payload counter is clear whenever no frame is open.
  a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (cnt_r == 7'd0))
    else $error("payload counter not clear outside a frame");

  // A word that continues a frame is either inside an open frame or closes it.
  a_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid_r && !job_r.start) |-> (in_frame_r || job_r.last))
    else $error("mid-frame word outside a frame");

endmodule

@@ dv/tb_ieee802154_frame_builder.sv @@
// Testbench for the 802.15.4 frame builder: a directed table and random frames
// checked word by word against an in-bench frame predictor with running CRC.
// Depends on fb_pkg, fb_if and the ieee802154_frame_builder top level.
module tb_ieee802154_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;
  import fb_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 450;
  localparam int HOLD_CYCLES    = 300;
  localparam int HOLD_PHASE     = 6;
  localparam int SETTLE_CYCLES  = 4;
  localparam int END_CYCLES     = 20;
  localparam int WATCHDOG_LIMIT = 3000;

  // Index past the last register; the block must ignore writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  // One directed step: a register write or a payload word, with the word
  // count and length byte typed in where they are obvious (zero: unchecked).
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [15:0]           data;
    logic [4:0]            exp_words;
    logic [7:0]            exp_len_byte;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       end_flag;
  } frame_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fb_in_if  in_ch ();
  fb_out_if out_ch ();

  ieee802154_frame_builder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Predictor state: register copies and the frame in progress.
  logic [15:0] fc_q, dpan_q, daddr_q, span_q, saddr_q;
  logic [7:0]  seq_q;
  logic [6:0]  len_q;
  logic [15:0] crc_q;
  logic [6:0]  taken_q;
  logic        framing_q;

  frame_word_t frame_words_q[$];
  stim_row_t   dir_rows[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  logic        no_idle;
  logic        hold_req;

  // Reflected CRC, one byte folded into the low end of the register.
  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Lengths below two act as two.
  function automatic logic [6:0] eff_length();
    return (len_q < MIN_LEN) ? MIN_LEN : len_q;
  endfunction

  function automatic int frame_bytes_left();
    if (!framing_q) return int'(eff_length());
    if (taken_q >= eff_length()) return 1;
    return int'(eff_length()) - int'(taken_q);
  endfunction

  task automatic reset_model();
    fc_q      = 16'h8841;
    seq_q     = 8'h01;
    dpan_q    = 16'h2222;
    daddr_q   = 16'h1234;
    span_q    = 16'h4444;
    saddr_q   = 16'hABCD;
    len_q     = 7'd8;
    crc_q     = CRC_INIT;
    taken_q   = '0;
    framing_q = 1'b0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    case (idx)
      REG_FRAME_CONTROL:   fc_q    = data;
      REG_SEQUENCE_NUMBER: seq_q   = data[7:0];
      REG_DEST_PAN_ID:     dpan_q  = data;
      REG_DEST_ADDRESS:    daddr_q = data;
      REG_SRC_PAN_ID:      span_q  = data;
      REG_SRC_ADDRESS:     saddr_q = data;
      REG_PAYLOAD_LENGTH:  len_q   = data[6:0];
      default: ;
    endcase
  endtask

  task automatic push_word(input logic [7:0] d, input logic fin, input logic in_crc);
    if (in_crc) crc_q = crc_update(crc_q, d);
    frame_words_q.push_back('{byte_val: d, end_flag: fin});
  endtask

  // Expected frame words caused by one payload word.
  task automatic predict_frame_words(input logic [7:0] b, output int n,
                                     output logic [7:0] len_byte);
    logic [7:0]  hdr [HDR_LEN];
    logic [6:0]  eff;
    logic [15:0] fcs;
    int          start;
    start    = frame_words_q.size();
    eff      = eff_length();
    len_byte = 8'h00;
    if (!framing_q) begin
      hdr = '{fc_q[7:0], fc_q[15:8], seq_q, dpan_q[7:0], dpan_q[15:8],
              daddr_q[7:0], daddr_q[15:8], span_q[7:0], span_q[15:8],
              saddr_q[7:0], saddr_q[15:8]};
      crc_q   = CRC_INIT;
      taken_q = '0;
      repeat (PREAMBLE_BYTES) push_word(8'h00, 1'b0, 1'b0);
      push_word(SFD_BYTE, 1'b0, 1'b0);
      len_byte = 8'(HDR_LEN + int'(eff) + FCS_LEN);
      push_word(len_byte, 1'b0, 1'b0);
      foreach (hdr[i]) push_word(hdr[i], 1'b0, 1'b1);
      framing_q = 1'b1;
    end
    push_word(b, 1'b0, 1'b1);
    taken_q = taken_q + 7'd1;
    // The frame closes as soon as the count reaches the current length.
    if (taken_q >= eff) begin
      fcs = ~crc_q;
      push_word(fcs[7:0], 1'b0, 1'b0);
      push_word(fcs[15:8], 1'b1, 1'b0);
      framing_q = 1'b0;
      taken_q   = '0;
      crc_q     = CRC_INIT;
    end
    n = frame_words_q.size() - start;
  endtask

  // Mostly short gaps, a few long ones, none in burst phases.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_field();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Mostly small payloads; upper data bits are random and must be dropped.
  function automatic logic [15:0] pick_length();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 3)       len = $urandom_range(100, 127);
    else if (r < 15) len = $urandom_range(0, 2);
    else if (r < 25) len = $urandom_range(11, 40);
    else             len = $urandom_range(1, 10);
    return {9'($urandom), 7'(len)};
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_random_regs();
    for (int k = 0; k <= REG_PAYLOAD_LENGTH; k++) begin
      if ($urandom_range(0, 1) == 1) begin
        write_reg(3'(k), (k == REG_PAYLOAD_LENGTH) ? pick_length() : pick_field());
      end
    end
    if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, 16'($urandom));
  endtask

  // Offer one payload word and predict its frame words once it is taken.
  task automatic send_word(input logic [7:0] b, output int n, output logic [7:0] len_byte);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    predict_frame_words(b, n, len_byte);
  endtask

  // Let every expected word come out, then let the pipeline settle.
  task automatic drain_frame_words();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (frame_words_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    dir_rows.push_back('{kind: ROW_CFG, idx: idx, data: data, exp_words: 5'd0,
                         exp_len_byte: 8'h00});
  endtask

  task automatic add_word(input logic [7:0] b, input logic [4:0] words,
                          input logic [7:0] len_byte);
    dir_rows.push_back('{kind: ROW_WORD, idx: REG_UNUSED, data: {8'h00, b},
                         exp_words: words, exp_len_byte: len_byte});
  endtask

  task automatic build_table();
    // Reset values, length eight: burst, six echoes, closing word with FCS.
    add_word(8'h00, 5'd18, 8'h15);
    add_word(8'hFF, 5'd1, 8'h00);
    add_word(8'h55, 5'd1, 8'h00);
    add_word(8'hAA, 5'd1, 8'h00);
    add_word(8'h01, 5'd1, 8'h00);
    add_word(8'h80, 5'd1, 8'h00);
    add_word(8'h7F, 5'd1, 8'h00);
    add_word(8'hFE, 5'd3, 8'h00);
    // Short payload of one acts as two.
    add_cfg(REG_PAYLOAD_LENGTH, 16'd1);
    add_word(8'h12, 5'd18, 8'h0F);
    add_word(8'h34, 5'd3, 8'h00);
    // Unknown index is ignored; then a length of zero, also acting as two.
    add_cfg(REG_UNUSED, 16'hFFFF);
    add_cfg(REG_PAYLOAD_LENGTH, 16'd0);
    add_word(8'hC3, 5'd18, 8'h0F);
    add_word(8'h3C, 5'd3, 8'h00);
    // Header fields at their extremes.
    add_cfg(REG_FRAME_CONTROL, 16'hFFFF);
    add_cfg(REG_SEQUENCE_NUMBER, 16'hFFFF);
    add_cfg(REG_DEST_PAN_ID, 16'h0000);
    add_cfg(REG_DEST_ADDRESS, 16'hFFFF);
    add_cfg(REG_SRC_PAN_ID, 16'h0000);
    add_cfg(REG_SRC_ADDRESS, 16'hFFFF);
    add_cfg(REG_PAYLOAD_LENGTH, 16'd3);
    add_word(8'hA5, 5'd18, 8'h10);
    // Header change inside a frame only affects the next frame.
    add_cfg(REG_SEQUENCE_NUMBER, 16'h0000);
    add_word(8'h5A, 5'd1, 8'h00);
    add_word(8'h0F, 5'd3, 8'h00);
    // Length lowered below the words already taken closes the frame at once.
    add_cfg(REG_PAYLOAD_LENGTH, 16'd6);
    add_word(8'hF0, 5'd18, 8'h13);
    add_word(8'h11, 5'd1, 8'h00);
    add_word(8'h22, 5'd1, 8'h00);
    add_cfg(REG_PAYLOAD_LENGTH, 16'd2);
    add_word(8'h33, 5'd3, 8'h00);
    // Longest length byte, then one with high data bits set that masks to one.
    add_cfg(REG_PAYLOAD_LENGTH, 16'd127);
    add_word(8'h96, 5'd18, 8'h8C);
    add_cfg(REG_PAYLOAD_LENGTH, 16'hFF81);
    add_word(8'h69, 5'd3, 8'h00);
  endtask

  // Stimulus: directed table, then random phases of register writes and frames.
  initial begin
    stim_row_t  row;
    int         n;
    logic [7:0] lb;
    int         phase;
    int         remaining;
    int         r;
    int         target;
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.payload_byte <= 8'h00;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_FRAME_CONTROL;
    cfg_wdata          <= '0;
    no_idle            <= 1'b0;
    hold_req           <= 1'b0;
    reset_model();
    build_table();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        drain_frame_words();
        write_reg(row.idx, row.data);
        end_writes();
      end else begin
        send_word(row.data[7:0], n, lb);
        if (row.exp_words != 0 && n != int'(row.exp_words)) begin
          mismatch_count++;
          $display("%0t: row %0d word count expected %0d actual %0d",
                   $time, i, row.exp_words, n);
        end
        if (row.exp_len_byte != 8'h00 && lb !== row.exp_len_byte) begin
          mismatch_count++;
          $display("%0t: row %0d length byte expected %02h actual %02h",
                   $time, i, row.exp_len_byte, lb);
        end
      end
    end

    phase  = 0;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      drain_frame_words();
      // One phase runs a long frame of length 114 against a long receiver hold-off.
      if (phase == HOLD_PHASE) write_reg(REG_PAYLOAD_LENGTH, 16'd114);
      else if (phase == 0 || $urandom_range(0, 1) == 1) write_random_regs();
      no_idle  <= (phase == HOLD_PHASE) || ($urandom_range(0, 4) == 0);
      hold_req <= (phase == HOLD_PHASE);
      end_writes();
      remaining = frame_bytes_left();
      r = $urandom_range(0, 99);
      // Some phases stop inside a frame so the next writes land mid-frame.
      if (phase != HOLD_PHASE && r < 20) remaining = $urandom_range(1, remaining);
      else if (r >= 85) remaining += int'(eff_length());
      repeat (remaining) send_word(8'($urandom_range(0, 255)), n, lb);
      phase++;
    end

    drain_frame_words();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off, and the word check.
  int   stall_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  task automatic check_word();
    frame_word_t want;
    if (frame_words_q.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected word expected none actual %02h end %0b",
               $time, out_ch.out_byte, out_ch.frame_end);
    end else begin
      want = frame_words_q.pop_front();
      if (out_ch.out_byte !== want.byte_val) begin
        mismatch_count++;
        $display("%0t: out_byte expected %02h actual %02h",
                 $time, want.byte_val, out_ch.out_byte);
      end
      if (out_ch.frame_end !== want.end_flag) begin
        mismatch_count++;
        $display("%0t: frame_end expected %0b actual %0b",
                 $time, want.end_flag, out_ch.frame_end);
      end
    end
  endtask

  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        g = pick_gap();
        out_ch.ready <= (g == 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  // Watchdog: too long without a word moving on either side ends the run.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

@@ files.f @@
design/fb_pkg.sv
design/fb_if.sv
design/fb_emitter.sv
design/ieee802154_frame_builder.sv
dv/tb_ieee802154_frame_builder.sv
